>>> hw/rtl/sbh_pkg.sv
// Shared types, constants and round functions for the SHA-256 byte stream hasher.
`timescale 1ns / 1ps

package sbh_pkg;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_COMP,
        ST_UPDATE,
        ST_EMIT
    } sbh_state_t;

    // Eight 32-bit words of hash or working state, word 0 in the top lane.
    typedef logic [7:0][31:0] sbh_hash_t;

    // Control from the sequencer to the datapath units.
    typedef struct packed {
        logic shift_byte;   // push one byte into the message window
        logic load_work;    // copy hash words into working variables
        logic round_en;     // run one compression round
        logic fold;         // add working variables into the hash words
        logic restore;      // return hash words to the initial values
    } sbh_ctl_t;

    localparam logic [5:0] LAST_BYTE    = 6'd63;
    localparam logic [5:0] LEN_POS      = 6'd56;
    localparam logic [5:0] LAST_ROUND   = 6'd63;
    localparam logic [2:0] LAST_INDEX   = 3'd7;
    localparam logic [7:0] PAD_MARK     = 8'h80;
    localparam logic [63:0] BLOCK_BITS  = 64'd512;

    localparam sbh_hash_t INIT_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

>>> hw/rtl/sbh_sched.sv
// Message window: byte buffer while loading, sliding message schedule while compressing.
`timescale 1ns / 1ps

module sbh_sched
    import sbh_pkg::*;
(
    input  logic        aclk,
    input  sbh_ctl_t    ctl,
    input  logic [7:0]  byte_in,
    output logic [31:0] w_cur
);

    // Sixteen words, w[t] in the top 32 bits.
    logic [511:0] win_reg;
    logic [511:0] win_next;
    logic [31:0]  w_new;

    // Next schedule word from the fixed taps of the window.
    assign w_new = small_sigma1(win_reg[511-32*14 -: 32]) + win_reg[511-32*9 -: 32]
                 + small_sigma0(win_reg[511-32*1 -: 32]) + win_reg[511 -: 32];

    assign w_cur = win_reg[511 -: 32];

    // Bytes enter at the bottom; rounds shift one word out of the top.
    always_comb begin
        win_next = win_reg;
        if (ctl.shift_byte) begin
            win_next = {win_reg[503:0], byte_in};
        end else if (ctl.round_en) begin
            win_next = {win_reg[479:0], w_new};
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

endmodule

>>> hw/rtl/sbh_round.sv
// Hash words and working variables with the shared one-round compression unit.
`timescale 1ns / 1ps

module sbh_round
    import sbh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  sbh_ctl_t    ctl,
    input  logic [31:0] k_cur,
    input  logic [31:0] w_cur,
    output sbh_hash_t   hash_words
);

    sbh_hash_t   hash_reg;
    sbh_hash_t   hash_next;
    sbh_hash_t   work_reg;
    sbh_hash_t   work_next;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] a_v;
    logic [31:0] e_v;

    assign a_v = work_reg[7];
    assign e_v = work_reg[3];

    // One round: lane 7 holds a, lane 0 holds h.
    assign t1 = work_reg[0] + big_sigma1(e_v) + ((e_v & work_reg[2]) ^ (~e_v & work_reg[1]))
              + k_cur + w_cur;
    assign t2 = big_sigma0(a_v) + ((a_v & work_reg[6]) ^ (a_v & work_reg[5])
              ^ (work_reg[6] & work_reg[5]));

    // Working variables: load, or step one round.
    always_comb begin
        work_next = work_reg;
        if (ctl.load_work) begin
            work_next = hash_reg;
        end else if (ctl.round_en) begin
            work_next[7] = t1 + t2;
            work_next[6] = work_reg[7];
            work_next[5] = work_reg[6];
            work_next[4] = work_reg[5];
            work_next[3] = work_reg[4] + t1;
            work_next[2] = work_reg[3];
            work_next[1] = work_reg[2];
            work_next[0] = work_reg[1];
        end
    end

    // Hash words: fold in after the last round, or go back to the initial values.
    always_comb begin
        hash_next = hash_reg;
        if (ctl.restore) begin
            hash_next = INIT_HASH;
        end else if (ctl.fold) begin
            for (int i = 0; i < 8; i++) begin
                hash_next[i] = hash_reg[i] + work_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= INIT_HASH;
        end else begin
            hash_reg <= hash_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
    end

    assign hash_words = hash_reg;

endmodule

>>> hw/rtl/sha256_byte_stream_hasher.sv
// Top level of the SHA-256 byte stream hasher: sequencer, counters and stream ports.
//
//  Channel | Ports            | Fields (lowest bit up)
//  --------+------------------+--------------------------------------------------------
//  input   | s_tvalid/s_tready| s_tdata: byte_value[7:0]; s_tuser: mode[0]
//  result  | m_tvalid/m_tready| m_tdata: digest_word[31:0], word_index[34:32], zero[39:35];
//          |                  | m_tlast: last_word
//
// Every 64th absorbed byte starts a compression of 64 rounds and a fold in the single round
// unit; no further byte is taken until that compression is done.
// A finish word is followed by zero padding and length bytes (8 to 71 over one or two blocks),
// one or two compressions, then eight result words, each held until taken.
// s_tready is high only in the idle state. Reset (aresetn low, synchronous) restores the
// initial hash values and clears the counts; no clearing pass is needed.
`timescale 1ns / 1ps

module sha256_byte_stream_hasher
    import sbh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // byte_value[7:0]
    input  logic [0:0]  s_tuser,    // mode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // digest_word[31:0], word_index[34:32], zero[39:35]
    output logic        m_tlast
);

    sbh_state_t  state_reg;
    sbh_state_t  state_next;
    sbh_state_t  after_reg;
    sbh_state_t  after_next;
    logic [5:0]  count_reg;
    logic [5:0]  round_reg;
    logic [2:0]  index_reg;
    logic [63:0] total_reg;
    logic [63:0] len_reg;
    sbh_ctl_t    ctl;
    logic [7:0]  byte_in;
    logic [31:0] w_cur;
    sbh_hash_t   hash_words;
    logic        s_acc;
    logic        m_acc;
    logic        done_emit;

    assign s_acc     = s_tvalid && s_tready;
    assign m_acc     = m_tvalid && m_tready;
    assign done_emit = m_acc && (index_reg == LAST_INDEX);

    // Next state and the state to resume after a compression.
    always_comb begin
        state_next = state_reg;
        after_next = after_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (s_tuser[0]) begin
                        after_next = ST_PAD;
                        state_next = (count_reg == LAST_BYTE) ? ST_COMP : ST_PAD;
                    end else begin
                        after_next = ST_IDLE;
                        state_next = (count_reg == LAST_BYTE) ? ST_COMP : ST_IDLE;
                    end
                end
            end
            ST_PAD: begin
                if (count_reg == LEN_POS) begin
                    state_next = ST_LEN;
                end else if (count_reg == LAST_BYTE) begin
                    after_next = ST_PAD;
                    state_next = ST_COMP;
                end
            end
            ST_LEN: begin
                if (count_reg == LAST_BYTE) begin
                    after_next = ST_EMIT;
                    state_next = ST_COMP;
                end
            end
            ST_COMP: begin
                if (round_reg == LAST_ROUND) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                state_next = after_reg;
            end
            ST_EMIT: begin
                if (done_emit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath control and handshake outputs.
    always_comb begin
        ctl        = '0;
        byte_in    = s_tdata;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready       = 1'b1;
                ctl.shift_byte = s_acc;
                byte_in        = s_tuser[0] ? PAD_MARK : s_tdata;
            end
            ST_PAD: begin
                ctl.shift_byte = (count_reg != LEN_POS);
                byte_in        = 8'h00;
            end
            ST_LEN: begin
                ctl.shift_byte = 1'b1;
                byte_in        = len_reg[63:56];
            end
            ST_COMP: begin
                ctl.round_en = 1'b1;
            end
            ST_UPDATE: begin
                ctl.fold = 1'b1;
            end
            ST_EMIT: begin
                m_tvalid    = 1'b1;
                ctl.restore = done_emit;
            end
            default: begin
                ctl = '0;
            end
        endcase
        ctl.load_work = (state_next == ST_COMP) && (state_reg != ST_COMP);
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            after_reg <= ST_IDLE;
            count_reg <= '0;
            round_reg <= '0;
            index_reg <= '0;
            total_reg <= '0;
        end else begin
            state_reg <= state_next;
            after_reg <= after_next;
            if (ctl.shift_byte) begin
                count_reg <= count_reg + 6'd1;
            end
            round_reg <= ctl.round_en ? round_reg + 6'd1 : '0;
            if (m_acc) begin
                index_reg <= index_reg + 3'd1;
            end
            if (done_emit) begin
                total_reg <= '0;
            end else if (ctl.fold && (after_reg == ST_IDLE)) begin
                total_reg <= total_reg + BLOCK_BITS;
            end
        end
    end

    // Message length in bits, latched at finish and sent out high byte first.
    always_ff @(posedge aclk) begin
        if (s_acc && s_tuser[0]) begin
            len_reg <= total_reg + {55'd0, count_reg, 3'd0};
        end else if (state_reg == ST_LEN) begin
            len_reg <= {len_reg[55:0], 8'h00};
        end
    end

    sbh_sched u_sched (
        .aclk    (aclk),
        .ctl     (ctl),
        .byte_in (byte_in),
        .w_cur   (w_cur)
    );

    sbh_round u_round (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .k_cur      (ROUND_K[round_reg]),
        .w_cur      (w_cur),
        .hash_words (hash_words)
    );

    // Digest words straight from the hash registers, word 0 first.
    assign m_tdata = {5'd0, index_reg, hash_words[3'd7 - index_reg]};
    assign m_tlast = (index_reg == LAST_INDEX);

`ifndef ASSERT_OFF
    // Input and result sides are never open at the same time.
    assert property (@(posedge aclk) disable iff (!aresetn) !(s_tready && m_tvalid))
        else $error("input ready while a digest word is pending");

    // After the last digest word the block takes input again.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("block did not return to idle after the digest");

    // A digest always starts at word zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> (m_tdata[34:32] == 3'd0))
        else $error("digest did not start at word zero");

    // The round counter only advances while compressing.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_COMP) |-> (round_reg == 6'd0))
        else $error("round counter active outside compression");
`endif

endmodule
